// ===== sv/kcc_pkg.sv =====
// Package for the keyword Caesar cipher: item kind and mode codes,
// character constants and the command/status structs between controller and datapath.
// Depends on nothing; every other file imports it.
package kcc_pkg;

	localparam int LETTERS = 26;

	// Item kinds.
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_TEXT  = 2'd2;

	// Cipher modes.
	localparam logic [1:0] MODE_PLAIN_ENC = 2'd0;
	localparam logic [1:0] MODE_PLAIN_DEC = 2'd1;
	localparam logic [1:0] MODE_KEY_ENC   = 2'd2;
	localparam logic [1:0] MODE_KEY_DEC   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_SHIFT = 2'd0;
	localparam logic [1:0] REG_MODE  = 2'd1;

	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UZ = 8'h5A;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LZ = 8'h7A;

	localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);

	typedef struct packed {
		logic clear;      // clear the keyed alphabet state
		logic key_write;  // place the keyword letter on the input
		logic text_load;  // cipher the input character into the output register
		logic fill_start; // latch the text character and start the alphabet fill
		logic fill_step;  // place the next letter of the fill
		logic emit;       // cipher the latched character into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic complete;
		logic fill_last;
		logic out_valid;
	} dp_sts_t;

endpackage

// ===== sv/kcc_ctrl.sv =====
// Controller of the keyword Caesar cipher: input handshake and the fill sequence.
// Depends on kcc_pkg.
module kcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        kind,
	input  logic              out_ready,
	input  kcc_pkg::dp_sts_t  sts,
	output logic              in_ready,
	output kcc_pkg::dp_cmd_t  cmd
);
	import kcc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FILL = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready = (state_q == ST_IDLE) && (!sts.out_valid || out_ready);
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd.clear      = acc && (kind == KIND_CLEAR);
		cmd.key_write  = acc && (kind == KIND_KEY) && !sts.complete;
		cmd.text_load  = acc && (kind == KIND_TEXT) && sts.complete;
		cmd.fill_start = acc && (kind == KIND_TEXT) && !sts.complete;
		cmd.fill_step  = (state_q == ST_FILL);
		cmd.emit       = (state_q == ST_EMIT);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.fill_start) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (sts.fill_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/kcc_dp.sv =====
// Datapath of the keyword Caesar cipher: registers, keyed alphabet tables,
// fill counter, cipher arithmetic and output register. Depends on kcc_pkg.
module kcc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  kcc_pkg::dp_cmd_t  cmd,
	input  logic [7:0]        character,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_index,
	input  logic [4:0]        cfg_data,
	input  logic              out_ready,
	output kcc_pkg::dp_sts_t  sts,
	output logic [7:0]        out_char,
	output logic              out_valid
);
	import kcc_pkg::*;

	logic [4:0]         shift_q;
	logic [1:0]         mode_q;
	logic [LETTERS-1:0] used_q;
	logic [4:0]         count_q;
	logic               complete_q;
	logic [4:0]         fill_q;
	logic [7:0]         char_q;
	logic [4:0]         fwd_q [LETTERS];
	logic [4:0]         inv_q [LETTERS];
	logic [7:0]         out_char_q;
	logic               out_valid_q;

	// Keyword letter decode.
	logic       key_up, key_lo;
	logic [7:0] key_off;
	logic [4:0] key_letter;

	// Letter placement shared by keyword items and the fill.
	logic [4:0] pl_letter;
	logic       pl_req, pl_ok;

	// Cipher arithmetic.
	logic [7:0] src;
	logic       is_up, is_lo;
	logic [7:0] src_off;
	logic [4:0] pos, sh_eff, pos_fw, res;
	logic [5:0] sum_fw;
	logic [7:0] result;

	// (x + 26 - sh) mod 26 for x and sh both below 26.
	function automatic logic [4:0] mod_back(input logic [4:0] x, input logic [4:0] sh);
		logic [5:0] t;
		t = {1'b0, x} + 6'(LETTERS) - {1'b0, sh};
		if (t >= 6'(LETTERS)) begin
			t = t - 6'(LETTERS);
		end
		return t[4:0];
	endfunction

	assign key_up     = (character >= CHAR_UA) && (character <= CHAR_UZ);
	assign key_lo     = (character >= CHAR_LA) && (character <= CHAR_LZ);
	assign key_off    = key_up ? (character - CHAR_UA) : (character - CHAR_LA);
	assign key_letter = key_off[4:0];

	assign pl_letter = cmd.fill_step ? fill_q : key_letter;
	assign pl_req    = cmd.fill_step || (cmd.key_write && (key_up || key_lo));
	assign pl_ok     = pl_req && (count_q < 5'(LETTERS)) && !used_q[pl_letter];

	assign src     = cmd.emit ? char_q : character;
	assign is_up   = (src >= CHAR_UA) && (src <= CHAR_UZ);
	assign is_lo   = (src >= CHAR_LA) && (src <= CHAR_LZ);
	assign src_off = is_up ? (src - CHAR_UA) : (src - CHAR_LA);
	assign pos     = src_off[4:0];
	assign sh_eff  = (shift_q >= 5'(LETTERS)) ? (shift_q - 5'(LETTERS)) : shift_q;
	assign sum_fw  = {1'b0, pos} + {1'b0, sh_eff};
	assign pos_fw  = (sum_fw >= 6'(LETTERS)) ? 5'(sum_fw - 6'(LETTERS)) : sum_fw[4:0];

	always_comb begin
		case (mode_q)
			MODE_PLAIN_ENC: res = pos_fw;
			MODE_PLAIN_DEC: res = mod_back(pos, sh_eff);
			MODE_KEY_ENC:   res = fwd_q[pos_fw];
			default:        res = mod_back(inv_q[pos], sh_eff);
		endcase
	end

	always_comb begin
		if (is_lo) begin
			result = CHAR_LA + {3'b000, res};
		end else if (is_up) begin
			result = CHAR_UA + {3'b000, res};
		end else begin
			result = src;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			mode_q  <= MODE_PLAIN_ENC;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SHIFT) begin
				shift_q <= cfg_data;
			end else if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[1:0];
			end
		end
	end

	// Keyed alphabet bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			count_q    <= '0;
			complete_q <= 1'b0;
			fill_q     <= '0;
		end else begin
			if (cmd.clear) begin
				used_q     <= '0;
				count_q    <= '0;
				complete_q <= 1'b0;
			end else begin
				if (pl_ok) begin
					used_q[pl_letter] <= 1'b1;
					count_q           <= count_q + 5'd1;
				end
				if (cmd.fill_step && sts.fill_last) begin
					complete_q <= 1'b1;
				end
			end
			if (cmd.fill_start) begin
				fill_q <= '0;
			end else if (cmd.fill_step) begin
				fill_q <= fill_q + 5'd1;
			end
		end
	end

	// Table contents and the latched text character need no reset.
	always_ff @(posedge clk) begin
		if (pl_ok) begin
			fwd_q[count_q]   <= pl_letter;
			inv_q[pl_letter] <= count_q;
		end
		if (cmd.fill_start) begin
			char_q <= character;
		end
		if (cmd.text_load || cmd.emit) begin
			out_char_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.text_load || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.complete  = complete_q;
	assign sts.fill_last = (fill_q == LAST_LETTER);
	assign sts.out_valid = out_valid_q;
	assign out_char      = out_char_q;
	assign out_valid     = out_valid_q;

`ifndef NO_ASSERTIONS
	// The placed-letter count always matches the number of letters marked as used.
	a_count_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == 32'(count_q))
		else $error("keyed alphabet count disagrees with used-letter mask");

	// A completed alphabet holds every letter exactly once.
	a_complete_full: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> (count_q == 5'(LETTERS)))
		else $error("alphabet marked complete with letters missing");

	// A new result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.text_load || cmd.emit) |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before it was taken");
`endif

endmodule

// ===== sv/keyword_caesar_cipher_top.sv =====
// Top level of the keyword Caesar cipher.
// Depends on kcc_pkg, kcc_ctrl and kcc_dp.
//
// Usage: items enter on in_valid/in_ready with fields kind and character.
// A clear item empties the keyword, a keyword item adds its letter (folded to
// lower case, repeats and non-letters ignored) and a text item yields one
// result item on out_valid/out_ready carrying out_char. Clear and keyword items
// give no result. Letter case is kept; other characters pass through.
// The shift and mode registers are written on cfg_valid with cfg_index and
// cfg_data; the port is always ready. The user must use it only while the
// block is idle; the block does not enforce this. The first text item after a
// reset or a clear first completes the keyed alphabet: the fill state walks the
// letters in order, placing each one not yet used, then the emit state ciphers
// the latched character; no input is accepted meanwhile. Any other text item is
// registered into the output and appears the cycle after it is accepted, and
// items are taken one per cycle while the output is drained. Reset clears the
// registers, the keyword and the output valid flag; the alphabet tables hold no
// reset value and are always written before use. When the receiver stalls, the
// result waits in the output register and in_ready falls until it is taken.
module keyword_caesar_cipher_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] character,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);
	import kcc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Configuration writes complete at once.
	assign cfg_ready = 1'b1;

	kcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	kcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.character (character),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.sts       (sts),
		.out_char  (out_char),
		.out_valid (out_valid)
	);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for keyword_caesar_cipher_top: directed and random items
// with their results checked against a predictor kept inside the bench.
// Depends on kcc_pkg and the RTL of the block; reads and writes no files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kcc_pkg::*;

	// Run limits.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDLE_PAUSE = 4;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD = 200;
	localparam int RANDOM_ITEMS = 1400;
	localparam int PHASE_ITEMS = 120;

	// Codes that the package leaves unnamed: the spare item kind and a spare register index.
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd2;
	localparam logic [1:0] MODE_ORDER [4] = '{MODE_PLAIN_ENC, MODE_PLAIN_DEC,
		MODE_KEY_ENC, MODE_KEY_DEC};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] character;
	} cipher_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = KIND_CLEAR;
	logic [7:0] character = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = REG_SHIFT;
	logic [4:0] cfg_data = 5'd0;

	// Register copies and keyed alphabet state of the predictor.
	logic [4:0]  shift_now = 5'd0;
	logic [1:0]  mode_now = MODE_PLAIN_ENC;
	logic [25:0] letters_taken = '0;
	int          alpha_len = 0;
	bit          alpha_done = 1'b0;
	logic [4:0]  keyed_alpha [LETTERS];
	logic [4:0]  keyed_pos [LETTERS];

	// Items waiting to be offered and ciphered characters waiting to come out.
	cipher_item_t pending_items [$];
	logic [7:0]   expected_chars [$];

	int queued_count = 0;
	int accepted_count = 0;
	int errors = 0;
	int cycle_count = 0;
	int tx_style = 1;
	int rx_style = 1;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	keyword_caesar_cipher_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.character (character),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap lengths: mostly none or short, now and then a long one. Style 0 means no gaps.
	function automatic int pick_gap(input int style);
		int r;
		r = $urandom_range(0, 99);
		if (style == 0 || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Appends a letter to the keyed alphabet unless it is already there or the alphabet is full.
	task automatic place_letter(input int letter);
		if (alpha_len < LETTERS && !letters_taken[letter]) begin
			keyed_alpha[alpha_len] = 5'(letter);
			keyed_pos[letter] = 5'(alpha_len);
			letters_taken[letter] = 1'b1;
			alpha_len++;
		end
	endtask

	// Updates the cipher state for one accepted item and queues the character it should give.
	task automatic cipher_item(input logic [1:0] k, input logic [7:0] c);
		int  step, pos, letter, l;
		bit  upper, is_letter;
		// A shift of 26 to 31 wraps round to 0 to 5.
		step = (shift_now >= 5'(LETTERS)) ? int'(shift_now) - LETTERS : int'(shift_now);
		upper = (c >= CHAR_UA && c <= CHAR_UZ);
		is_letter = upper || (c >= CHAR_LA && c <= CHAR_LZ);
		pos = upper ? int'(c) - int'(CHAR_UA) : int'(c) - int'(CHAR_LA);
		case (k)
			KIND_CLEAR: begin
				// The tables keep their contents; only the bookkeeping starts afresh.
				letters_taken = '0;
				alpha_len = 0;
				alpha_done = 1'b0;
			end
			KIND_KEY: begin
				// Keyword letters are ignored once the alphabet has been completed.
				if (!alpha_done && is_letter)
					place_letter(pos);
			end
			KIND_TEXT: begin
				// The first text item after a clear completes the alphabet in letter order.
				if (!alpha_done) begin
					for (l = 0; l < LETTERS; l++)
						place_letter(l);
					alpha_done = 1'b1;
				end
				if (!is_letter) begin
					expected_chars.push_back(c);
				end else begin
					case (mode_now)
						MODE_PLAIN_ENC: letter = (pos + step) % LETTERS;
						MODE_PLAIN_DEC: letter = (pos + LETTERS - step) % LETTERS;
						MODE_KEY_ENC:   letter = int'(keyed_alpha[(pos + step) % LETTERS]);
						default:        letter = (int'(keyed_pos[pos]) + LETTERS - step) % LETTERS;
					endcase
					expected_chars.push_back((upper ? CHAR_UA : CHAR_LA) + 8'(letter));
				end
			end
			default: ;
		endcase
	endtask

	// Driver: offers queued items, holds each one until it is taken, then perhaps idles.
	always @(posedge clk) begin : drive_items
		cipher_item_t item;
		logic         drive_valid;
		if (in_valid && in_ready) begin
			cipher_item(kind, character);
			accepted_count++;
		end
		if (!in_valid || in_ready) begin
			drive_valid = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (pending_items.size() > 0) begin
				item = pending_items.pop_front();
				kind <= item.kind;
				character <= item.character;
				drive_valid = 1'b1;
				tx_gap = pick_gap(tx_style);
			end
			in_valid <= drive_valid;
		end
	end

	// Monitor: checks each result item against the oldest expected character and drives
	// out_ready, with random gaps and, on request, one long hold-off counted here.
	always @(posedge clk) begin : check_results
		logic [7:0] want;
		logic       take;
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: result item with none expected, out_char %h", $time, out_char);
				errors++;
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want) begin
					$display("%0t: out_char mismatch, expected %h, actual %h",
						$time, want, out_char);
					errors++;
				end
			end
		end
		if (hold_left == 0 && hold_served != hold_requests) begin
			hold_served++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			take = 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			take = 1'b0;
		end else begin
			take = 1'b1;
			rx_gap = pick_gap(rx_style);
		end
		out_ready <= take;
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_item(input logic [1:0] k, input logic [7:0] c);
		cipher_item_t item;
		item.kind = k;
		item.character = c;
		pending_items.push_back(item);
		queued_count++;
	endtask

	// Writes one register; only called while the block is idle.
	task automatic write_reg(input logic [1:0] reg_index, input logic [4:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (reg_index == REG_SHIFT)
			shift_now = value;
		else if (reg_index == REG_MODE)
			mode_now = value[1:0];
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued item has been taken and every result has come out, then
	// lets a keyword item that may still be in flight settle.
	task automatic wait_idle();
		@(posedge clk);
		while (accepted_count != queued_count || expected_chars.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE)
			@(posedge clk);
	endtask

	function automatic logic [7:0] any_letter();
		return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'($urandom_range(0, LETTERS - 1));
	endfunction

	// Text characters: mostly letters, some fixed edge values, the rest anything.
	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return any_letter();
		if (r < 75) begin
			case ($urandom_range(0, 7))
				0:       return CHAR_UA - 8'd1;
				1:       return CHAR_UZ + 8'd1;
				2:       return CHAR_LA - 8'd1;
				3:       return CHAR_LZ + 8'd1;
				4:       return 8'h00;
				5:       return 8'hFF;
				6:       return 8'h7F;
				default: return 8'h80;
			endcase
		end
		return 8'($urandom());
	endfunction

	// Queues one sequence. Most are well formed: a clear, a keyword with repeats, mixed case
	// and stray non-letters, then text. The rest is noise of any kind, the spare one included.
	task automatic queue_sequence(output int counted);
		int         key_items, text_items, i;
		logic [1:0] k;
		logic [7:0] last_key;
		int         r;
		counted = 0;
		if ($urandom_range(0, 99) < 75) begin
			queue_item(KIND_CLEAR, 8'($urandom()));
			counted++;
			key_items = $urandom_range(0, 12);
			last_key = any_letter();
			for (i = 0; i < key_items; i++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					last_key = any_letter();
				else if (r < 80)
					last_key = last_key ^ 8'h20;
				else
					last_key = 8'($urandom());
				queue_item(KIND_KEY, last_key);
				counted++;
			end
			text_items = $urandom_range(1, 20);
			for (i = 0; i < text_items; i++) begin
				// Now and then a keyword letter comes in among the text; after the first text item it does nothing.
				if ($urandom_range(0, 19) == 0) begin
					queue_item(KIND_KEY, any_letter());
				end else begin
					queue_item(KIND_TEXT, text_char());
					counted++;
				end
			end
		end else begin
			text_items = $urandom_range(1, 6);
			for (i = 0; i < text_items; i++) begin
				k = 2'($urandom());
				queue_item(k, 8'($urandom()));
				if (k != KIND_SPARE)
					counted++;
			end
		end
	endtask

	initial begin : stimulus
		int phase, counted, phase_count, total;
		logic [4:0] shift_pick;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: plain encrypt with no shift, so text comes back as it went in.
		queue_item(KIND_TEXT, "a");
		queue_item(KIND_TEXT, 8'h7F);
		wait_idle();

		// Largest shift value, which wraps to 5, in plain decrypt at the alphabet edges.
		write_reg(REG_SHIFT, 5'd31);
		write_reg(REG_MODE, 5'(MODE_PLAIN_DEC));
		queue_item(KIND_TEXT, "a");
		queue_item(KIND_TEXT, "Z");
		queue_item(KIND_TEXT, CHAR_LZ + 8'd1);
		queue_item(KIND_TEXT, CHAR_UA - 8'd1);
		queue_item(KIND_TEXT, CHAR_LA - 8'd1);
		wait_idle();

		// Keyed encrypt: folded and repeated keyword letters, a non-letter, the spare kind,
		// and a keyword letter after the alphabet is complete. The spare register is ignored.
		write_reg(REG_SPARE, 5'd7);
		write_reg(REG_SHIFT, 5'd0);
		write_reg(REG_MODE, 5'(MODE_KEY_ENC));
		queue_item(KIND_CLEAR, 8'h00);
		queue_item(KIND_KEY, "Z");
		queue_item(KIND_KEY, "e");
		queue_item(KIND_KEY, "b");
		queue_item(KIND_KEY, "E");
		queue_item(KIND_KEY, "1");
		queue_item(KIND_SPARE, "q");
		queue_item(KIND_TEXT, "a");
		queue_item(KIND_TEXT, "B");
		queue_item(KIND_TEXT, "z");
		queue_item(KIND_KEY, "x");
		queue_item(KIND_TEXT, "d");
		wait_idle();

		// Keyed decrypt with the largest in-range shift, then a clear with an empty keyword.
		write_reg(REG_SHIFT, 5'd25);
		write_reg(REG_MODE, 5'(MODE_KEY_DEC));
		queue_item(KIND_TEXT, "z");
		queue_item(KIND_TEXT, "Z");
		queue_item(KIND_TEXT, "e");
		queue_item(KIND_CLEAR, 8'hFF);
		queue_item(KIND_TEXT, "m");
		queue_item(KIND_TEXT, 8'hFF);
		queue_item(KIND_TEXT, 8'h00);

		// Random phases. Each one starts from an idle block, so the sender has waited for
		// every result, and sets both registers; the first four use the shift extremes.
		total = 0;
		phase = 0;
		while (total < RANDOM_ITEMS) begin
			wait_idle();
			case (phase)
				0:       shift_pick = 5'd0;
				1:       shift_pick = 5'd25;
				2:       shift_pick = 5'd26;
				3:       shift_pick = 5'd31;
				default: shift_pick = 5'($urandom_range(0, 31));
			endcase
			write_reg(REG_SHIFT, shift_pick);
			write_reg(REG_MODE, 5'(MODE_ORDER[phase % 4]));
			tx_style = (phase % 3 != 2);
			rx_style = (phase % 4 != 3);
			// A long receiver hold-off while the sender keeps offering fills the block up.
			if (phase == 1 || phase == 6)
				hold_requests++;
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				queue_sequence(counted);
				phase_count += counted;
			end
			total += phase_count;
			phase++;
		end

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/kcc_pkg.sv
sv/kcc_ctrl.sv
sv/kcc_dp.sv
sv/keyword_caesar_cipher_top.sv
sim/tb.sv
